FILE: rtl/shas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shas_pkg
// Shared types and SHA-256 constants for the stream hasher.
// ----------------------------------------------------------------------------
package shas_pkg;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } item_t;

    // queue head as seen by the engine
    typedef struct packed {
        logic  valid;
        item_t item;
    } qhead_t;

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] val;
        case (idx)
            3'd0:    val = 32'h6a09e667;
            3'd1:    val = 32'hbb67ae85;
            3'd2:    val = 32'h3c6ef372;
            3'd3:    val = 32'ha54ff53a;
            3'd4:    val = 32'h510e527f;
            3'd5:    val = 32'h9b05688c;
            3'd6:    val = 32'h1f83d9ab;
            default: val = 32'h5be0cd19;
        endcase
        return val;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] val;
        case (r)
            6'd0:  val = 32'h428a2f98;  6'd1:  val = 32'h71374491;
            6'd2:  val = 32'hb5c0fbcf;  6'd3:  val = 32'he9b5dba5;
            6'd4:  val = 32'h3956c25b;  6'd5:  val = 32'h59f111f1;
            6'd6:  val = 32'h923f82a4;  6'd7:  val = 32'hab1c5ed5;
            6'd8:  val = 32'hd807aa98;  6'd9:  val = 32'h12835b01;
            6'd10: val = 32'h243185be;  6'd11: val = 32'h550c7dc3;
            6'd12: val = 32'h72be5d74;  6'd13: val = 32'h80deb1fe;
            6'd14: val = 32'h9bdc06a7;  6'd15: val = 32'hc19bf174;
            6'd16: val = 32'he49b69c1;  6'd17: val = 32'hefbe4786;
            6'd18: val = 32'h0fc19dc6;  6'd19: val = 32'h240ca1cc;
            6'd20: val = 32'h2de92c6f;  6'd21: val = 32'h4a7484aa;
            6'd22: val = 32'h5cb0a9dc;  6'd23: val = 32'h76f988da;
            6'd24: val = 32'h983e5152;  6'd25: val = 32'ha831c66d;
            6'd26: val = 32'hb00327c8;  6'd27: val = 32'hbf597fc7;
            6'd28: val = 32'hc6e00bf3;  6'd29: val = 32'hd5a79147;
            6'd30: val = 32'h06ca6351;  6'd31: val = 32'h14292967;
            6'd32: val = 32'h27b70a85;  6'd33: val = 32'h2e1b2138;
            6'd34: val = 32'h4d2c6dfc;  6'd35: val = 32'h53380d13;
            6'd36: val = 32'h650a7354;  6'd37: val = 32'h766a0abb;
            6'd38: val = 32'h81c2c92e;  6'd39: val = 32'h92722c85;
            6'd40: val = 32'ha2bfe8a1;  6'd41: val = 32'ha81a664b;
            6'd42: val = 32'hc24b8b70;  6'd43: val = 32'hc76c51a3;
            6'd44: val = 32'hd192e819;  6'd45: val = 32'hd6990624;
            6'd46: val = 32'hf40e3585;  6'd47: val = 32'h106aa070;
            6'd48: val = 32'h19a4c116;  6'd49: val = 32'h1e376c08;
            6'd50: val = 32'h2748774c;  6'd51: val = 32'h34b0bcb5;
            6'd52: val = 32'h391c0cb3;  6'd53: val = 32'h4ed8aa4a;
            6'd54: val = 32'h5b9cca4f;  6'd55: val = 32'h682e6ff3;
            6'd56: val = 32'h748f82ee;  6'd57: val = 32'h78a5636f;
            6'd58: val = 32'h84c87814;  6'd59: val = 32'h8cc70208;
            6'd60: val = 32'h90befffa;  6'd61: val = 32'ha4506ceb;
            6'd62: val = 32'hbef9a3f7;  6'd63: val = 32'hc67178f2;
            default: val = 32'h0;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/shas_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shas_front
// Input side: takes item transfers into a short queue for the engine.
// ----------------------------------------------------------------------------
module shas_front #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  shas_pkg::item_t      item_in,
    output shas_pkg::qhead_t     head,
    input  logic                 pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    shas_pkg::item_t   mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              push, do_pop;

    assign item_stall = (count_reg == CW'(DEPTH));
    assign push       = item_valid && !item_stall;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
            end
            if (push && !do_pop)
            begin
                count_reg <= CW'(count_reg + 1'b1);
            end
            else if (do_pop && !push)
            begin
                count_reg <= CW'(count_reg - 1'b1);
            end
        end
    end

endmodule

FILE: rtl/shas_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shas_engine
// Back end: block packing, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
module shas_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  shas_pkg::qhead_t   head,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [31:0]        digest_word,
    output logic [2:0]         word_index,
    output logic               last_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_LEN   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    localparam logic [1:0] RET_IDLE = 2'd0;
    localparam logic [1:0] RET_PAD  = 2'd1;
    localparam logic [1:0] RET_EMIT = 2'd2;

    logic [2:0]   state_reg, state_next;
    logic [1:0]   ret_reg, ret_next;
    logic [5:0]   pos_reg, pos_next;
    logic [63:0]  bits_reg, bits_next;
    logic [5:0]   round_reg, round_next;
    logic [2:0]   lenc_reg, lenc_next;
    logic [2:0]   idx_reg, idx_next;
    logic [511:0] win_reg, win_next;     // block buffer and schedule window
    logic [31:0]  h_reg [8];
    logic [31:0]  h_next [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  v_next [8];

    logic [31:0]  x1, x14, s0, s1, wr, t1, t2, e, a;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb
    begin
        x1  = win_reg[479:448];
        x14 = win_reg[63:32];
        s0  = ror(x1, 7) ^ ror(x1, 18) ^ (x1 >> 3);
        s1  = ror(x14, 17) ^ ror(x14, 19) ^ (x14 >> 10);
        wr  = (round_reg < 6'd16) ? win_reg[511:480]
            : win_reg[511:480] + s0 + s1 + win_reg[223:192];
        e   = v_reg[4];
        a   = v_reg[0];
        t1  = v_reg[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) +
              ((e & v_reg[5]) ^ (~e & v_reg[6])) + shas_pkg::round_k(round_reg) + wr;
        t2  = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) +
              ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        pos_next   = pos_reg;
        bits_next  = bits_reg;
        round_next = round_reg;
        lenc_next  = lenc_reg;
        idx_next   = idx_reg;
        win_next   = win_reg;
        h_next     = h_reg;
        v_next     = v_reg;
        pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop      = 1'b1;
                    pos_next = 6'(pos_reg + 1'b1);
                    if (head.item.kind == shas_pkg::KIND_BYTE)
                    begin
                        win_next  = {win_reg[503:0], head.item.data};
                        bits_next = 64'(bits_reg + 64'd8);
                        ret_next  = RET_IDLE;
                    end
                    else
                    begin
                        win_next   = {win_reg[503:0], 8'h80};
                        ret_next   = RET_PAD;
                        state_next = ST_PAD;
                    end
                    if (pos_reg == 6'd63)
                    begin
                        v_next     = h_reg;
                        round_next = '0;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                win_next   = {win_reg[479:0], wr};
                v_next[7]  = v_reg[6];
                v_next[6]  = v_reg[5];
                v_next[5]  = v_reg[4];
                v_next[4]  = v_reg[3] + t1;
                v_next[3]  = v_reg[2];
                v_next[2]  = v_reg[1];
                v_next[1]  = v_reg[0];
                v_next[0]  = t1 + t2;
                round_next = 6'(round_reg + 1'b1);
                if (round_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int j = 0; j < 8; j++)
                begin
                    h_next[j] = h_reg[j] + v_reg[j];
                end
                case (ret_reg)
                    RET_PAD:  state_next = ST_PAD;
                    RET_EMIT: state_next = ST_EMIT;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_PAD:
            begin
                if (pos_reg == 6'd56)
                begin
                    lenc_next  = '0;
                    state_next = ST_LEN;
                end
                else
                begin
                    win_next = {win_reg[503:0], 8'h00};
                    pos_next = 6'(pos_reg + 1'b1);
                    if (pos_reg == 6'd63)
                    begin
                        ret_next   = RET_PAD;
                        v_next     = h_reg;
                        round_next = '0;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_LEN:
            begin
                win_next  = {win_reg[503:0], bits_reg[63:56]};
                bits_next = {bits_reg[55:0], 8'h00};
                pos_next  = 6'(pos_reg + 1'b1);
                lenc_next = 3'(lenc_reg + 1'b1);
                if (lenc_reg == 3'd7)
                begin
                    ret_next   = RET_EMIT;
                    v_next     = h_reg;
                    round_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_EMIT:
            begin
                if (!result_stall)
                begin
                    idx_next = 3'(idx_reg + 1'b1);
                    if (idx_reg == 3'd7)
                    begin
                        for (int j = 0; j < 8; j++)
                        begin
                            h_next[j] = shas_pkg::init_h(3'(j));
                        end
                        bits_next  = '0;
                        pos_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = (state_reg == ST_EMIT);
    assign digest_word  = h_reg[idx_reg];
    assign word_index   = idx_reg;
    assign last_word    = (idx_reg == 3'd7);

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        v_reg   <= v_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= RET_IDLE;
            pos_reg   <= '0;
            bits_reg  <= '0;
            round_reg <= '0;
            lenc_reg  <= '0;
            idx_reg   <= '0;
            for (int j = 0; j < 8; j++)
            begin
                h_reg[j] <= shas_pkg::init_h(3'(j));
            end
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            pos_reg   <= pos_next;
            bits_reg  <= bits_next;
            round_reg <= round_next;
            lenc_reg  <= lenc_next;
            idx_reg   <= idx_next;
            h_reg     <= h_next;
        end
    end

endmodule

FILE: rtl/sha256_stream_hasher_core.sv
`timescale 1ns / 1ps
// A message byte is shifted into the block buffer as it leaves the queue; every 64th
//   byte starts a compression (64 rounds plus the hash add), during which no bytes are taken.
// A finish item writes the marker, then pads and appends the length one byte per cycle
//   while no compression is running, runs one or two compressions, then presents
//   8 digest words, one per transfer.
// Reset (rst_n, async, active low) empties the input queue and loads the initial hash.
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 over a byte stream: input queue in front, compression engine behind.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    shas_pkg::item_t  item_in;
    shas_pkg::qhead_t head;
    logic             pop;

    assign item_in.kind = kind;
    assign item_in.data = data_byte;

    shas_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_in    (item_in),
        .head       (head),
        .pop        (pop)
    );

    shas_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

`ifndef ASSERT_OFF
    // after the final digest word the engine goes back to taking bytes
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && last_word |=> !result_valid)
        else $error("digest output continued past the last word");

    // digest words leave in order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !last_word |=>
            result_valid && word_index == 3'($past(word_index) + 3'd1))
        else $error("digest word index out of sequence");
`endif

endmodule
